>>> sv/smh_pkg.sv
// Shared types, constants and round functions for the SHA-1 message hasher.
package smh_pkg;

    localparam int ROUNDS     = 80;
    localparam int BLOCK_BITS = 512;

    typedef logic [4:0][31:0] t_digest;

    // Initial chaining value, word 0 in the lowest slot.
    localparam t_digest H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    // Round constant for each group of twenty rounds.
    localparam logic [3:0][31:0] K_ROUND = {
        32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
    };

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [5:0] LEN_START = 6'd55;
    localparam logic [2:0] LAST_WORD = 3'd4;
    localparam logic [2:0] LAST_LEN  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    // Where the sequencer goes once a compression has been folded in.
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_OUT
    } t_ret;

    typedef struct packed {
        logic       init;
        logic       shift;
        logic [7:0] shift_data;
        logic       load;
        logic       round;
        logic       fold;
    } t_core_cmd;

    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

>>> sv/sha1_message_hasher_top.sv
// Top level of the SHA-1 message hasher: sequencer, round datapath and digest read-out.
// A data byte request is taken when idle; every 64th byte also runs a compression (load, 80 rounds, fold).
// A finish request pads one byte per cycle outside the compressions and runs one or two
// compressions, then offers five digest words, one per accepted output cycle.
// Data bytes are not taken during a compression; the one-round-per-cycle unit sets its pace.
// Synchronous active-low reset loads the initial chaining value and clears all counters.
module sha1_message_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    // Commands from the sequencer to the datapath travel as one struct.
    smh_pkg::t_core_cmd core_cmd;
    logic               last_round;
    smh_pkg::t_digest   digest;

    // The sequencer owns both handshakes. It accepts a request only when idle, so a
    // request is never taken while a compression or the digest read-out is under way.
    smh_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_cmd        (core_cmd),
        .i_last_round (last_round)
    );

    // The datapath keeps the block in a 512-bit shift register that also serves as the
    // sliding message schedule, so one round unit is reused for all 80 rounds.
    smh_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (core_cmd),
        .o_last_round (last_round),
        .o_h          (digest)
    );

    // The digest words come straight from the chaining registers, which hold still
    // while the words are offered, so the payload is stable until taken.
    assign o_digest_word = digest[o_word_index];

endmodule

>>> sv/smh_core.sv
// Compression datapath: block shift register, one shared round unit, chaining state.
module smh_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smh_pkg::t_core_cmd  i_cmd,
    output logic                o_last_round,
    output smh_pkg::t_digest    o_h
);

    logic [smh_pkg::BLOCK_BITS-1:0] r_w;
    logic [31:0]                    r_a, r_b, r_c, r_d, r_e;
    smh_pkg::t_digest               r_h;
    logic [6:0]                     r_rnd;

    logic [31:0] w0, w2, w8, w13, w_mix, w_new, f_val, t_val;
    logic [1:0]  grp;

    // During the rounds the window holds w[i] .. w[i+15]; the schedule word for i+16 is appended.
    assign w0    = r_w[511:480];
    assign w2    = r_w[447:416];
    assign w8    = r_w[255:224];
    assign w13   = r_w[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        if (r_rnd < 7'd20) begin
            grp = 2'd0;
        end else if (r_rnd < 7'd40) begin
            grp = 2'd1;
        end else if (r_rnd < 7'd60) begin
            grp = 2'd2;
        end else begin
            grp = 2'd3;
        end
    end

    assign f_val = smh_pkg::round_f(grp, r_b, r_c, r_d);
    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + smh_pkg::K_ROUND[grp] + w0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= smh_pkg::H_INIT;
            r_rnd <= '0;
        end else begin
            if (i_cmd.init) begin
                r_h <= smh_pkg::H_INIT;
            end else if (i_cmd.fold) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.load) begin
                r_rnd <= '0;
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_w <= {r_w[smh_pkg::BLOCK_BITS-9:0], i_cmd.shift_data};
        end else if (i_cmd.round) begin
            r_w <= {r_w[smh_pkg::BLOCK_BITS-33:0], w_new};
        end
        if (i_cmd.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_last_round = (r_rnd == 7'(smh_pkg::ROUNDS - 1));
    assign o_h          = r_h;

`ifndef SYNTHESIS
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round |-> (r_rnd < 7'(smh_pkg::ROUNDS)))
        else $error("round counter ran past the last round");
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_rnd == 7'd0))
        else $error("round counter not cleared on load");
    a_no_shift_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round |-> !i_cmd.shift)
        else $error("byte shifted in during a compression");
`endif

endmodule

>>> sv/smh_seq.sv
// Sequencer: byte intake, padding, compression steps and digest read-out.
module smh_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [7:0]          i_data_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_word_index,
    output logic                o_last_word,
    output smh_pkg::t_core_cmd  o_cmd,
    input  logic                i_last_round
);

    smh_pkg::t_state r_state, n_state;
    smh_pkg::t_ret   r_ret, n_ret;
    logic [5:0]      r_cnt, n_cnt;
    logic [60:0]     r_len, n_len;
    logic [63:0]     r_lsh, n_lsh;
    logic [2:0]      r_pcnt, n_pcnt;
    logic [2:0]      r_oidx, n_oidx;

    logic in_acc, data_acc, fin_acc, out_acc, out_done;

    assign in_acc   = i_valid && o_ready;
    assign data_acc = in_acc && !i_kind;
    assign fin_acc  = in_acc && i_kind;
    assign out_acc  = o_valid && i_ready;
    assign out_done = out_acc && (r_oidx == smh_pkg::LAST_WORD);

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state) inside
            smh_pkg::ST_IDLE: begin
                if (data_acc && r_cnt == smh_pkg::LAST_BYTE) begin
                    n_state = smh_pkg::ST_LOAD;
                    n_ret   = smh_pkg::RET_IDLE;
                end else if (fin_acc) begin
                    n_state = smh_pkg::ST_PAD_MARK;
                end
            end
            smh_pkg::ST_PAD_MARK, smh_pkg::ST_PAD_ZERO: begin
                if (r_cnt == smh_pkg::LAST_BYTE) begin
                    n_state = smh_pkg::ST_LOAD;
                    n_ret   = smh_pkg::RET_PAD;
                end else if (r_cnt == smh_pkg::LEN_START) begin
                    n_state = smh_pkg::ST_PAD_LEN;
                end else begin
                    n_state = smh_pkg::ST_PAD_ZERO;
                end
            end
            smh_pkg::ST_PAD_LEN: begin
                if (r_pcnt == smh_pkg::LAST_LEN) begin
                    n_state = smh_pkg::ST_LOAD;
                    n_ret   = smh_pkg::RET_OUT;
                end
            end
            smh_pkg::ST_LOAD: begin
                n_state = smh_pkg::ST_ROUND;
            end
            smh_pkg::ST_ROUND: begin
                if (i_last_round) begin
                    n_state = smh_pkg::ST_FOLD;
                end
            end
            smh_pkg::ST_FOLD: begin
                unique case (r_ret)
                    smh_pkg::RET_PAD: n_state = smh_pkg::ST_PAD_ZERO;
                    smh_pkg::RET_OUT: n_state = smh_pkg::ST_OUT;
                    default:          n_state = smh_pkg::ST_IDLE;
                endcase
            end
            smh_pkg::ST_OUT: begin
                if (out_done) begin
                    n_state = smh_pkg::ST_IDLE;
                end
            end
            default: n_state = smh_pkg::ST_IDLE;
        endcase
    end

    // Outputs and core commands.
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            smh_pkg::ST_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.shift      = data_acc;
                o_cmd.shift_data = i_data_byte;
            end
            smh_pkg::ST_PAD_MARK: begin
                o_cmd.shift      = 1'b1;
                o_cmd.shift_data = smh_pkg::PAD_MARK;
            end
            smh_pkg::ST_PAD_ZERO: begin
                o_cmd.shift = 1'b1;
            end
            smh_pkg::ST_PAD_LEN: begin
                o_cmd.shift      = 1'b1;
                o_cmd.shift_data = r_lsh[63:56];
            end
            smh_pkg::ST_LOAD:  o_cmd.load  = 1'b1;
            smh_pkg::ST_ROUND: o_cmd.round = 1'b1;
            smh_pkg::ST_FOLD:  o_cmd.fold  = 1'b1;
            smh_pkg::ST_OUT: begin
                o_valid    = 1'b1;
                o_cmd.init = out_done;
            end
            default: o_cmd = '0;
        endcase
    end

    // Counters and the length shifter.
    always_comb begin
        n_cnt  = o_cmd.shift ? r_cnt + 6'd1 : r_cnt;
        n_len  = r_len;
        n_lsh  = r_lsh;
        n_pcnt = r_pcnt;
        n_oidx = r_oidx;
        if (data_acc) begin
            n_len = r_len + 61'd1;
        end else if (out_done) begin
            n_len = '0;
        end
        if (fin_acc) begin
            n_lsh = {r_len, 3'b000};
        end else if (r_state == smh_pkg::ST_PAD_LEN) begin
            n_lsh  = {r_lsh[55:0], 8'h00};
            n_pcnt = r_pcnt + 3'd1;
        end
        if (out_acc) begin
            n_oidx = out_done ? 3'd0 : r_oidx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smh_pkg::ST_IDLE;
            r_ret   <= smh_pkg::RET_IDLE;
            r_cnt   <= '0;
            r_len   <= '0;
            r_pcnt  <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_pcnt  <= n_pcnt;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lsh <= n_lsh;
    end

    assign o_word_index = r_oidx;
    assign o_last_word  = (r_oidx == smh_pkg::LAST_WORD);

`ifndef SYNTHESIS
    a_load_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smh_pkg::ST_LOAD) |-> (r_cnt == 6'd0))
        else $error("compression started on a partial block");
    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smh_pkg::ST_PAD_LEN && r_pcnt == 3'd0) |-> (r_cnt == 6'd56))
        else $error("length field not placed at byte 56");
    a_clean_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done |=> (r_state == smh_pkg::ST_IDLE && r_len == 61'd0 && r_cnt == 6'd0))
        else $error("message state not cleared after the digest");
`endif

endmodule
